// ----- src/gmp_pkg.sv -----
// Shared types and constants for the grid max path sum block.
package gmp_pkg;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // Widths fixed by the interface fields
    localparam int CELL_IDX_W = 4;
    localparam int VAL_W      = 16;
    localparam int TOT_W      = 20;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    // Counters hold 0..127 (wider than any configurable row or column count)
    localparam int CNT_W      = 7;

    localparam logic [CFG_W-1:0] COUNT_RESET = 5'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store the accepted cell
        logic start_comp;  // latch column counter, begin compute
        logic col_start;   // reset row counter, read next-column entry 0
        logic prime;       // seed the neighbor window
        logic cell_rd;     // read grid cell and next-column entry row+1
        logic cell_calc;   // form the cell total and write it
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_row;
        logic last_col;
    } stat_t;

endpackage

// ----- src/gmp_ram.sv -----
// Generic simple dual-port RAM with registered read.
module gmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/gmp_ctrl.sv -----
// Controller state machine for the grid max path sum block.
module gmp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           is_last,
    input  gmp_pkg::stat_t stat,
    output gmp_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_START,
        ST_PRIME,
        ST_CELL_RD,
        ST_CELL_CALC
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.load   = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_last)
                begin
                    cmd.start_comp = 1'b1;
                    busy_next      = 1'b1;
                    state_next     = ST_COL_START;
                end
            end
            ST_COL_START:
            begin
                cmd.col_start = 1'b1;
                state_next    = ST_PRIME;
            end
            ST_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = ST_CELL_RD;
            end
            ST_CELL_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = ST_CELL_CALC;
            end
            ST_CELL_CALC:
            begin
                cmd.cell_calc = 1'b1;
                priority if (!stat.last_row)
                begin
                    state_next = ST_CELL_RD;
                end
                else if (!stat.last_col)
                begin
                    state_next = ST_COL_START;
                end
                else
                begin
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- src/gmp_datapath.sv -----
// Datapath: grid store, column buffers, neighbor window and running best.
module gmp_datapath #(
    parameter int MAX_ROWS = gmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmp_pkg::DEF_MAX_COLS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gmp_pkg::cmd_t                   cmd,
    output gmp_pkg::stat_t                  stat,
    input  logic [gmp_pkg::CELL_IDX_W-1:0]  cell_row,
    input  logic [gmp_pkg::CELL_IDX_W-1:0]  cell_col,
    input  logic [gmp_pkg::VAL_W-1:0]       cell_value,
    input  logic                            cfg_we,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmp_pkg::CFG_W-1:0]       cfg_data,
    output logic [gmp_pkg::TOT_W-1:0]       max_gold
);

    localparam int CW    = gmp_pkg::CNT_W;
    localparam int TW    = gmp_pkg::TOT_W;
    localparam int VW    = gmp_pkg::VAL_W;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int GRID_DEPTH = 2 ** (ROW_W + COL_W);
    localparam int BUF_DEPTH  = 2 ** ROW_W;

    logic [gmp_pkg::CFG_W-1:0] row_count_reg, row_count_next;
    logic [gmp_pkg::CFG_W-1:0] col_count_reg, col_count_next;
    logic [CW-1:0]             row_reg, row_next;
    logic [CW-1:0]             col_reg, col_next;
    logic                      cur_sel_reg, cur_sel_next;
    logic [TW-1:0]             up_reg, up_next;
    logic [TW-1:0]             mid_reg, mid_next;
    logic [TW-1:0]             best_reg, best_next;

    logic [CW-1:0] rows, cols, cols_m1, row_plus1;
    logic [CW-1:0] in_row, in_col;
    logic          in_range, has_next;
    logic [VW-1:0] grid_q;
    logic [TW-1:0] buf0_q, buf1_q, nxt_q, dn, m_ud, m_all, total;
    logic [TW:0]   sum;
    logic [ROW_W-1:0] buf_raddr;

    // Clamp the configured counts into 1..MAX
    always_comb
    begin
        priority if (row_count_reg == '0)
            rows = CW'(1);
        else if (CW'(row_count_reg) > CW'(MAX_ROWS))
            rows = CW'(MAX_ROWS);
        else
            rows = CW'(row_count_reg);
        priority if (col_count_reg == '0)
            cols = CW'(1);
        else if (CW'(col_count_reg) > CW'(MAX_COLS))
            cols = CW'(MAX_COLS);
        else
            cols = CW'(col_count_reg);
    end

    assign cols_m1   = cols - CW'(1);
    assign row_plus1 = row_reg + CW'(1);
    assign has_next  = (col_reg != cols_m1);
    assign in_row    = CW'(cell_row);
    assign in_col    = CW'(cell_col);
    assign in_range  = (in_row < CW'(MAX_ROWS)) && (in_col < CW'(MAX_COLS));

    assign stat.last_row = (row_plus1 == rows);
    assign stat.last_col = (col_reg == '0);

    gmp_ram #(
        .WIDTH (VW),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (cmd.load && in_range),
        .waddr ({in_row[ROW_W-1:0], in_col[COL_W-1:0]}),
        .wdata (cell_value),
        .re    (cmd.cell_rd),
        .raddr ({row_reg[ROW_W-1:0], col_reg[COL_W-1:0]}),
        .rdata (grid_q)
    );

    assign buf_raddr = cmd.col_start ? '0 : row_plus1[ROW_W-1:0];

    gmp_ram #(
        .WIDTH (TW),
        .DEPTH (BUF_DEPTH)
    ) u_buf0 (
        .clk   (clk),
        .we    (cmd.cell_calc && !cur_sel_reg),
        .waddr (row_reg[ROW_W-1:0]),
        .wdata (total),
        .re    (cmd.col_start || cmd.cell_rd),
        .raddr (buf_raddr),
        .rdata (buf0_q)
    );

    gmp_ram #(
        .WIDTH (TW),
        .DEPTH (BUF_DEPTH)
    ) u_buf1 (
        .clk   (clk),
        .we    (cmd.cell_calc && cur_sel_reg),
        .waddr (row_reg[ROW_W-1:0]),
        .wdata (total),
        .re    (cmd.col_start || cmd.cell_rd),
        .raddr (buf_raddr),
        .rdata (buf1_q)
    );

    // Read the buffer not being written this column
    assign nxt_q = cur_sel_reg ? buf0_q : buf1_q;

    // Down-right neighbor exists only inside the grid and when a next column exists
    assign dn    = (has_next && (row_plus1 < rows)) ? nxt_q : '0;
    assign m_ud  = (up_reg > dn) ? up_reg : dn;
    assign m_all = (mid_reg > m_ud) ? mid_reg : m_ud;
    assign sum   = {1'b0, m_all} + (TW + 1)'(grid_q);
    assign total = sum[TW] ? '1 : sum[TW-1:0];

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cur_sel_next   = cur_sel_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        best_next      = best_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                gmp_pkg::REG_ROW_COUNT: row_count_next = cfg_data;
                gmp_pkg::REG_COL_COUNT: col_count_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.start_comp)
        begin
            col_next     = cols_m1;
            cur_sel_next = 1'b0;
        end

        if (cmd.col_start)
        begin
            row_next = '0;
        end

        if (cmd.prime)
        begin
            up_next  = '0;
            mid_next = has_next ? nxt_q : '0;
            if (stat.last_col)
            begin
                best_next = '0;
            end
        end

        if (cmd.cell_calc)
        begin
            up_next  = mid_reg;
            mid_next = dn;
            row_next = row_plus1;
            if (stat.last_col && (total > best_reg))
            begin
                best_next = total;
            end
            if (stat.last_row)
            begin
                cur_sel_next = !cur_sel_reg;
                if (!stat.last_col)
                begin
                    col_next = col_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= gmp_pkg::COUNT_RESET;
            col_count_reg <= gmp_pkg::COUNT_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_sel_reg   <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cur_sel_reg   <= cur_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg   <= up_next;
        mid_reg  <= mid_next;
        best_reg <= best_next;
    end

    assign max_gold = best_reg;

endmodule

// ----- src/grid_max_path_sum_dp.sv -----
// Top level of the grid max path sum block: controller plus datapath.
//
// Usage:
//   Load cells with start/busy: a beat is taken at a rising edge where start
//   is high and busy is low; one cell (cell_row, cell_col, cell_value) per
//   cycle. Cells outside MAX_ROWS x MAX_COLS are dropped. The beat with
//   is_last set also stores its cell, then raises busy and runs the compute.
//   Compute walks columns right to left. Each column first seeds the
//   neighbor window (row counter reset and buffer read, then prime); each
//   cell then takes a grid and column buffer read, then an add and write.
//   Column zero's running maximum is tracked during its pass, so no final
//   sweep is needed.
//   The result shows on max_gold with done high for exactly one cycle; the
//   receiver cannot stall it. busy drops in that same cycle, so the next
//   load beat may be taken alongside the result.
//   Configuration: cfg_valid/cfg_ready write row_count (index 0) or
//   col_count (index 1); cfg_ready is low while busy or start is high.
//   Counts of zero act as one, counts above the maximum act as the maximum.
//   Reset: counts return to 4, the controller goes idle; grid contents are
//   undefined until written.
module grid_max_path_sum_dp #(
    parameter int MAX_ROWS = gmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmp_pkg::DEF_MAX_COLS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [gmp_pkg::CELL_IDX_W-1:0]  cell_row,
    input  logic [gmp_pkg::CELL_IDX_W-1:0]  cell_col,
    input  logic [gmp_pkg::VAL_W-1:0]       cell_value,
    input  logic                            is_last,
    output logic                            done,
    output logic [gmp_pkg::TOT_W-1:0]       max_gold,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmp_pkg::CFG_W-1:0]       cfg_data
);

    gmp_pkg::cmd_t  cmd;
    gmp_pkg::stat_t stat;

    // Hold off configuration while a compute is running or a beat is offered,
    // so the counts never change at the edge that closes a grid
    assign cfg_ready = !busy && !start;

    gmp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_last (is_last),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    gmp_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cell_value (cell_value),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .max_gold   (max_gold)
    );

endmodule

// ----- src/gmp_checker.sv -----
// Port-level checker for the grid max path sum block, with its bind.
module gmp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic is_last,
    input logic done,
    input logic cfg_ready
);

    // Result beat only arrives as the compute ends
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // Result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Compute starts only from a last-cell beat
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && $past(is_last)))
        else $error("busy rose without a last beat");

    // A plain load beat never starts a compute
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !is_last) |=> !busy)
        else $error("busy after a non-last beat");

    // Configuration is blocked during compute
    a_cfg_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("cfg_ready while busy");

endmodule

bind grid_max_path_sum_dp gmp_checker u_gmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .is_last   (is_last),
    .done      (done),
    .cfg_ready (cfg_ready)
);
